@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro names one concurrent
// assertion clocked on the rising edge and switched off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants
// Operation codes, the scan token that walks the cell chain and the
// update command that is broadcast to every cell at the end of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Fixed-width part of the scan token; index, rank and count travel beside it.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] found_data;
    logic              vic_ok;
    logic [DATA_W-1:0] vic_key;
    logic              free_ok;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic              hit;
    logic              put;
    logic              evict;
    logic              insert;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/lfu_cache_lru_tiebreak_top.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top: LFU key/value cache, LRU tie break
// Request channel (req_valid/req_stall) carries kind, key and value; the
// response channel (rsp_valid/rsp_stall) returns hit, read_value, evicted
// and evicted_key, one response word per request word.
// Each request is handled by a token that walks the chain of ENTRIES entry
// cells, one cell per cycle, collecting the key match, the eviction victim
// (lowest use count, oldest among equals) and the first free slot. A last
// state, ST_DONE, broadcasts the update to all cells and loads the response
// register. A new request is accepted only in the idle state, after the
// previous one is done. The response register lets the next request be
// accepted and scanned while the previous response is held under
// rsp_stall; a finished scan waits only if the response register is still
// full. The capacity register is written over cfg_valid/cfg_ready, and
// the user must see that it is written only while idle; the block itself
// does not enforce this. Synchronous reset empties the cache, sets
// capacity to 16 and drops any pending response.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfu_cache_lru_tiebreak_top #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lfu_pkg::CAP_W-1:0]     capacity,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          kind,
  input  wire logic signed [lfu_pkg::DATA_W-1:0] key,
  input  wire logic signed [lfu_pkg::DATA_W-1:0] value,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic                               hit,
  output logic signed [lfu_pkg::DATA_W-1:0]  read_value,
  output logic                               evicted,
  output logic signed [lfu_pkg::DATA_W-1:0]  evicted_key
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0] ENT_CMP   = CMP_W'(ENTRIES);
  localparam logic [OCC_W-1:0] ENT_OCC   = OCC_W'(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IDX_W-1:0]  step;
  logic [CAP_W-1:0]  cap_limit;
  logic [OCC_W-1:0]  occupancy;
  logic              kind_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;

  logic              req_take;
  logic              rsp_take;
  logic              load;

  tok_t                   tok        [ENTRIES+1];
  logic [IDX_W-1:0]       found_idx  [ENTRIES+1];
  logic [IDX_W-1:0]       found_rank [ENTRIES+1];
  logic [IDX_W-1:0]       vic_idx    [ENTRIES+1];
  logic [IDX_W-1:0]       vic_rank   [ENTRIES+1];
  logic [COUNT_WIDTH-1:0] vic_count  [ENTRIES+1];
  logic [IDX_W-1:0]       free_idx   [ENTRIES+1];

  tok_t              last;
  cmd_t              cmd;
  logic [IDX_W-1:0]  cmd_ins_idx;
  logic [IDX_W-1:0]  cmd_rank;

  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              cap_zero;
  logic              occ_full;
  logic              is_put;
  logic              do_hit;
  logic              do_evict;
  logic              do_insert;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign load      = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  // Cell chain; the first cell sees an empty token.
  assign tok[0]        = '0;
  assign found_idx[0]  = '0;
  assign found_rank[0] = '0;
  assign vic_idx[0]    = '0;
  assign vic_rank[0]   = '0;
  assign vic_count[0]  = '0;
  assign free_idx[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .IDX         (i),
      .IDX_W       (IDX_W),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmp_key        (key_q),
      .tok_in         (tok[i]),
      .in_found_idx   (found_idx[i]),
      .in_found_rank  (found_rank[i]),
      .in_vic_idx     (vic_idx[i]),
      .in_vic_rank    (vic_rank[i]),
      .in_vic_count   (vic_count[i]),
      .in_free_idx    (free_idx[i]),
      .tok_out        (tok[i+1]),
      .out_found_idx  (found_idx[i+1]),
      .out_found_rank (found_rank[i+1]),
      .out_vic_idx    (vic_idx[i+1]),
      .out_vic_rank   (vic_rank[i+1]),
      .out_vic_count  (vic_count[i+1]),
      .out_free_idx   (free_idx[i+1]),
      .cmd            (cmd),
      .cmd_hit_idx    (found_idx[ENTRIES]),
      .cmd_vic_idx    (vic_idx[ENTRIES]),
      .cmd_ins_idx    (cmd_ins_idx),
      .cmd_rank       (cmd_rank)
    );
  end

  assign last      = tok[ENTRIES];
  assign cap_ext   = CMP_W'(cap_limit);
  assign eff_cap   = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
  assign cap_zero  = (cap_limit == '0);
  assign occ_full  = (CMP_W'(occupancy) >= eff_cap);
  assign is_put    = (kind_q == KIND_PUT);
  assign do_hit    = !cap_zero && last.found;
  assign do_evict  = !cap_zero && !last.found && is_put && occ_full && last.vic_ok;
  assign do_insert = !cap_zero && !last.found && is_put && (do_evict || last.free_ok);

  // Lowest free slot wins, the victim's slot counts as free.
  assign cmd_ins_idx = (do_evict && !(last.free_ok &&
                        (free_idx[ENTRIES] < vic_idx[ENTRIES]))) ?
                       vic_idx[ENTRIES] : free_idx[ENTRIES];
  assign cmd_rank    = last.found ? found_rank[ENTRIES] : vic_rank[ENTRIES];

  always_comb begin
    cmd        = '0;
    cmd.en     = load;
    cmd.hit    = do_hit;
    cmd.put    = is_put;
    cmd.evict  = do_evict;
    cmd.insert = do_insert;
    cmd.key    = key_q;
    cmd.data   = value_q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (step == LAST_STEP) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      cap_limit <= CAP_RESET;
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req_take) begin
        step <= '0;
      end else if (state == ST_SCAN) begin
        step <= step + IDX_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        cap_limit <= capacity;
      end
      if (load) begin
        occupancy <= occupancy + OCC_W'(do_insert) - OCC_W'(do_evict);
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      kind_q  <= kind;
      key_q   <= key;
      value_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit         <= do_hit;
      read_value  <= (do_hit && !is_put) ? last.found_data : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? last.vic_key : '0;
    end
  end

  `ASSERT_SAME(a_evict_excl, clk, rst, rsp_valid && evicted, !hit && (read_value == '0), "eviction reported together with a hit")
  `ASSERT_SAME(a_occ_bound, clk, rst, 1'b1, occupancy <= ENT_OCC, "occupancy exceeds entry count")
  `ASSERT_NEXT(a_take_scan, clk, rst, req_take, state == ST_SCAN, "accepted word did not start a scan")
  `ASSERT_SAME(a_evict_full, clk, rst, load && do_evict, occ_full && !cap_zero, "eviction while room remains")

endmodule

`default_nettype wire

@@ hw/rtl/lfu_cell.sv @@
// ----------------------------------------------------------------------------
// lfu_cell: one cache entry
// Holds key, data, use count and recency rank of one entry. Folds its entry
// into the scan token and registers the token for the next cell; applies
// the broadcast update command to its own fields.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cell #(
  parameter int IDX         = 0,
  parameter int IDX_W       = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [lfu_pkg::DATA_W-1:0]   cmp_key,
  input  wire lfu_pkg::tok_t                tok_in,
  input  wire logic [IDX_W-1:0]             in_found_idx,
  input  wire logic [IDX_W-1:0]             in_found_rank,
  input  wire logic [IDX_W-1:0]             in_vic_idx,
  input  wire logic [IDX_W-1:0]             in_vic_rank,
  input  wire logic [COUNT_WIDTH-1:0]       in_vic_count,
  input  wire logic [IDX_W-1:0]             in_free_idx,
  output lfu_pkg::tok_t                     tok_out,
  output logic [IDX_W-1:0]                  out_found_idx,
  output logic [IDX_W-1:0]                  out_found_rank,
  output logic [IDX_W-1:0]                  out_vic_idx,
  output logic [IDX_W-1:0]                  out_vic_rank,
  output logic [COUNT_WIDTH-1:0]            out_vic_count,
  output logic [IDX_W-1:0]                  out_free_idx,
  input  wire lfu_pkg::cmd_t                cmd,
  input  wire logic [IDX_W-1:0]             cmd_hit_idx,
  input  wire logic [IDX_W-1:0]             cmd_vic_idx,
  input  wire logic [IDX_W-1:0]             cmd_ins_idx,
  input  wire logic [IDX_W-1:0]             cmd_rank
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0]       MY_IDX    = IDX_W'(IDX);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  logic                   valid;
  logic [DATA_W-1:0]      key_q;
  logic [DATA_W-1:0]      data;
  logic [COUNT_WIDTH-1:0] count;
  logic [IDX_W-1:0]       rank;

  logic                   hit_here;
  logic                   take_vic;
  logic                   me_hit;
  logic                   me_vic;
  logic                   me_ins;

  tok_t                   tok_next;
  logic [IDX_W-1:0]       found_idx_next;
  logic [IDX_W-1:0]       found_rank_next;
  logic [IDX_W-1:0]       vic_idx_next;
  logic [IDX_W-1:0]       vic_rank_next;
  logic [COUNT_WIDTH-1:0] vic_count_next;
  logic [IDX_W-1:0]       free_idx_next;

  assign hit_here = valid && (key_q == cmp_key);
  assign take_vic = valid && (!tok_in.vic_ok || (count < in_vic_count) ||
                    ((count == in_vic_count) && (rank > in_vic_rank)));
  assign me_hit   = (MY_IDX == cmd_hit_idx);
  assign me_vic   = cmd.evict && (MY_IDX == cmd_vic_idx);
  assign me_ins   = (MY_IDX == cmd_ins_idx);

  // Fold this entry into the passing token.
  always_comb begin
    tok_next        = tok_in;
    found_idx_next  = in_found_idx;
    found_rank_next = in_found_rank;
    vic_idx_next    = in_vic_idx;
    vic_rank_next   = in_vic_rank;
    vic_count_next  = in_vic_count;
    free_idx_next   = in_free_idx;
    if (!tok_in.found && hit_here) begin
      tok_next.found      = 1'b1;
      tok_next.found_data = data;
      found_idx_next      = MY_IDX;
      found_rank_next     = rank;
    end
    if (take_vic) begin
      tok_next.vic_ok  = 1'b1;
      tok_next.vic_key = key_q;
      vic_idx_next     = MY_IDX;
      vic_rank_next    = rank;
      vic_count_next   = count;
    end
    if (!tok_in.free_ok && !valid) begin
      tok_next.free_ok = 1'b1;
      free_idx_next    = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    tok_out        <= tok_next;
    out_found_idx  <= found_idx_next;
    out_found_rank <= found_rank_next;
    out_vic_idx    <= vic_idx_next;
    out_vic_rank   <= vic_rank_next;
    out_vic_count  <= vic_count_next;
    out_free_idx   <= free_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.en && cmd.insert) begin
      if (me_ins) begin
        valid <= 1'b1;
      end else if (me_vic) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.hit) begin
        if (me_hit) begin
          if (count != COUNT_MAX) begin
            count <= count + COUNT_ONE;
          end
          rank <= '0;
          if (cmd.put) begin
            data <= cmd.data;
          end
        end else if (valid && (rank < cmd_rank)) begin
          // age entries newer than the touched one
          rank <= rank + IDX_W'(1);
        end
      end else if (cmd.insert) begin
        if (me_ins) begin
          key_q <= cmd.key;
          data  <= cmd.data;
          count <= COUNT_ONE;
          rank  <= '0;
        end else if (valid && !me_vic) begin
          // close the gap left by the victim, then age for the new entry
          if (!(cmd.evict && (rank > cmd_rank))) begin
            rank <= rank + IDX_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: LFU key/value cache with LRU tie break
// Drives get/put words into the request channel and predicts each response
// with a cycle-free copy of the cache: per-entry valid, key, data, use count
// and recency rank. Responses are checked in order against the predictions.
// Capacity is changed between traffic phases while the cache is idle, from
// zero through the saturating values. Use counts are three bits wide so that
// saturation is reached. Both sides idle at random, the responder holds off
// once for a long stretch, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ENTRIES   = 16;
  localparam int CNT_W     = 3;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int QUIET_MAX = 4000;
  localparam int HOLD_LEN  = 300;
  localparam int POOL_LEN  = 32;

  typedef struct packed {
    logic                      kind;
    logic [lfu_pkg::DATA_W-1:0] key;
    logic [lfu_pkg::DATA_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::DATA_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::DATA_W-1:0] evicted_key;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [lfu_pkg::CAP_W-1:0]        capacity = lfu_pkg::CAP_RESET;
  logic                             req_valid = 1'b0;
  logic                             req_stall;
  logic                             kind = lfu_pkg::KIND_GET;
  logic signed [lfu_pkg::DATA_W-1:0] key = '0;
  logic signed [lfu_pkg::DATA_W-1:0] value = '0;
  logic                             rsp_valid;
  logic                             rsp_stall = 1'b0;
  logic                             hit;
  logic signed [lfu_pkg::DATA_W-1:0] read_value;
  logic                             evicted;
  logic signed [lfu_pkg::DATA_W-1:0] evicted_key;

  // Predicted cache contents
  logic [lfu_pkg::CAP_W-1:0]  cap_reg = lfu_pkg::CAP_RESET;
  bit                         ent_valid [ENTRIES];
  logic [lfu_pkg::DATA_W-1:0] ent_key   [ENTRIES];
  logic [lfu_pkg::DATA_W-1:0] ent_data  [ENTRIES];
  int                         ent_count [ENTRIES];
  int                         ent_age   [ENTRIES];
  int                         occupancy = 0;

  req_word_t                  pending_reqs[$];
  rsp_word_t                  expected_rsps[$];
  logic [lfu_pkg::DATA_W-1:0] key_pool [POOL_LEN];

  int error_count = 0;
  int quiet_cycles = 0;
  bit req_taken = 1'b0;
  bit steady = 1'b0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  lfu_cache_lru_tiebreak_top #(
    .ENTRIES    (ENTRIES),
    .COUNT_WIDTH(CNT_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .key        (key),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .evicted_key(evicted_key)
  );

  always #10 clk = ~clk;

  // Apply one get or put to the predicted cache and return its response word.
  function automatic rsp_word_t cache_access(logic op, logic [lfu_pkg::DATA_W-1:0] k,
                                             logic [lfu_pkg::DATA_W-1:0] v);
    rsp_word_t r;
    int lim, e, vic, slot, age, i;
    r = '0;
    lim = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    if (lim == 0) return r;
    e = -1;
    for (i = 0; i < ENTRIES; i++)
      if (e < 0 && ent_valid[i] && ent_key[i] == k) e = i;
    if (e >= 0) begin
      r.hit = 1'b1;
      if (op == lfu_pkg::KIND_GET) r.read_value = ent_data[e];
      else ent_data[e] = v;
      if (ent_count[e] < CNT_MAX) ent_count[e]++;
      // make it most recent; entries newer than it age by one
      age = ent_age[e];
      for (i = 0; i < ENTRIES; i++)
        if (ent_valid[i] && i != e && ent_age[i] < age) ent_age[i]++;
      ent_age[e] = 0;
      return r;
    end
    if (op == lfu_pkg::KIND_GET) return r;
    if (occupancy >= lim) begin
      vic = -1;
      for (i = 0; i < ENTRIES; i++) begin
        if (ent_valid[i] && (vic < 0 || ent_count[i] < ent_count[vic] ||
            (ent_count[i] == ent_count[vic] && ent_age[i] > ent_age[vic])))
          vic = i;
      end
      if (vic >= 0) begin
        age = ent_age[vic];
        r.evicted = 1'b1;
        r.evicted_key = ent_key[vic];
        ent_valid[vic] = 1'b0;
        occupancy--;
        for (i = 0; i < ENTRIES; i++)
          if (ent_valid[i] && ent_age[i] > age) ent_age[i]--;
      end
    end
    slot = -1;
    for (i = 0; i < ENTRIES; i++)
      if (slot < 0 && !ent_valid[i]) slot = i;
    if (slot < 0) return r;
    for (i = 0; i < ENTRIES; i++)
      if (ent_valid[i]) ent_age[i]++;
    ent_valid[slot] = 1'b1;
    ent_key[slot]   = k;
    ent_data[slot]  = v;
    ent_count[slot] = 1;
    ent_age[slot]   = 0;
    occupancy++;
    return r;
  endfunction

  // Request driver: present a new word only once the current one is taken.
  always @(negedge clk) begin : drive_req
    req_word_t w;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        w = pending_reqs[0];
        pending_reqs.delete(0);
        req_valid <= 1'b1;
        kind      <= w.kind;
        key       <= w.key;
        value     <= w.value;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 25);
    end
  end

  // Predict on each accepted request, check each accepted response, and
  // end the run if nothing moves for too long.
  always @(posedge clk) begin : observe
    rsp_word_t got, want, pred;
    if (rst) begin
      req_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken = req_valid && !req_stall;
      if (req_taken) begin
        pred = cache_access(kind, key, value);
        expected_rsps = {expected_rsps, pred};
      end
      if (rsp_valid && !rsp_stall) begin
        got = {hit, read_value, evicted, evicted_key};
        if (expected_rsps.size() == 0) begin
          $display("%0t: response word with nothing outstanding: %s%0b %s%h %s%0b %s%h",
                   $time, "hit=", got.hit, "read_value=", got.read_value,
                   "evicted=", got.evicted, "evicted_key=", got.evicted_key);
          error_count++;
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            error_count++;
          end
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, got.read_value);
            error_count++;
          end
          if (got.evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b actual %0b", $time,
                     want.evicted, got.evicted);
            error_count++;
          end
          if (got.evicted_key !== want.evicted_key) begin
            $display("%0t: evicted_key expected %h actual %h", $time,
                     want.evicted_key, got.evicted_key);
            error_count++;
          end
        end
      end
      if (req_taken || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_MAX);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_word(logic op, logic [31:0] k, logic [31:0] v);
    req_word_t w;
    w = '{kind: op, key: k, value: v};
    pending_reqs = {pending_reqs, w};
  endtask

  // Mostly keys from a pool of span keys, a few hot ones, some fully random.
  task automatic queue_traffic(int n, int span);
    int roll;
    logic [31:0] k;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) k = $urandom;
      else if (roll < 40) k = key_pool[$urandom_range(0, 2)];
      else k = key_pool[$urandom_range(0, span - 1)];
      push_word(1'($urandom_range(0, 1)), k, $urandom);
    end
  endtask

  // Hold until every word has gone out and every response has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    capacity  <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cap_reg = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_count[i] = 0;
      ent_age[i]   = 0;
    end
    for (int i = 0; i < POOL_LEN; i++) key_pool[i] = $urandom;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h8000_0000;
    key_pool[5] = 32'h0000_0000;
    key_pool[6] = 32'hFFFF_FFFF;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme keys and values, update hit, miss, count saturation
    push_word(lfu_pkg::KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    push_word(lfu_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_word(lfu_pkg::KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_word(lfu_pkg::KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_word(lfu_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_word(lfu_pkg::KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    push_word(lfu_pkg::KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    push_word(lfu_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
    push_word(lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    push_word(lfu_pkg::KIND_GET, 32'h0000_0001, 32'h0000_0000);
    push_word(lfu_pkg::KIND_PUT, 32'h0000_0000, 32'h1234_5678);
    repeat (7) push_word(lfu_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
    push_word(lfu_pkg::KIND_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    push_word(lfu_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);

    // Capacity above the entry count saturates
    set_capacity(5'd31);
    queue_traffic(150, 24);
    // Zero: entries stay but every get misses
    set_capacity(5'd0);
    queue_traffic(20, 24);
    // Lowered below occupancy: each new put evicts
    set_capacity(5'd3);
    queue_traffic(80, 8);
    set_capacity(5'd1);
    queue_traffic(40, 3);
    set_capacity(5'd16);
    hold_go = 1'b1;
    queue_traffic(150, 20);
    set_capacity(5'd5);
    steady = 1'b1;
    queue_traffic(80, 8);
    wait_idle();
    steady = 1'b0;
    set_capacity(5'($urandom_range(0, 31)));
    queue_traffic(60, 12);
    set_capacity(5'd17);
    queue_traffic(60, 24);

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_rsps.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cell.sv
hw/rtl/lfu_cache_lru_tiebreak_top.sv
sim/testbench.sv
